### hw/rtl/i2cdec_pkg.sv
package i2cdec_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned PinsW   = 8;
  localparam int unsigned RunW    = 8;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned LineW   = 4;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 4;
  localparam int unsigned LastBit = 7;

  // Event codes
  localparam logic [CodeW-1:0] EvStart     = 4'd0;
  localparam logic [CodeW-1:0] EvRepStart  = 4'd1;
  localparam logic [CodeW-1:0] EvStop      = 4'd2;
  localparam logic [CodeW-1:0] EvAck       = 4'd3;
  localparam logic [CodeW-1:0] EvNack      = 4'd4;
  localparam logic [CodeW-1:0] EvReadAddr  = 4'd5;
  localparam logic [CodeW-1:0] EvWriteAddr = 4'd6;
  localparam logic [CodeW-1:0] EvDataRead  = 4'd7;
  localparam logic [CodeW-1:0] EvDataWrite = 4'd8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegClockLine  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDataLine   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInvert     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegAddrShift  = 2'd3;

  localparam logic [LineW-1:0] ClockLineRst = 4'd1;
  localparam logic [LineW-1:0] DataLineRst  = 4'd2;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhAddr  = 2'd1,
    PhData  = 2'd2,
    PhAck   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [7:0]         byte_val;
    logic [SampleW-1:0] span;
    logic [CntW-1:0]    bits;
    logic [SampleW-1:0] start;
    logic               last;
  } result_t;

endpackage

### hw/rtl/i2c_bus_sample_decoder_top.sv
// I2C decoder over run-length captures of SCL and SDA.
// Each item passes through the input register before its results are written to the
// result queue; a second result of an item leaves the queue after the first.
// Throughput: one item per cycle while each causes at most one event and the output
// does not stall. The result port drains one event per cycle through a four-entry queue
// while out_stall_i is low. Input stalls while the queue lacks room for two events.
// Asynchronous reset returns decoder state, queue pointers and configuration to defaults.
module i2c_bus_sample_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i2cdec_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [i2cdec_pkg::CfgDatW-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [i2cdec_pkg::RunW-1:0]       run_minus_one_i,
  input  logic [i2cdec_pkg::PinsW-1:0]      pins_i,
  input  logic                              first_of_capture_i,
  input  logic                              last_of_capture_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [i2cdec_pkg::CodeW-1:0]      event_code_o,
  output logic [7:0]                        byte_value_o,
  output logic [i2cdec_pkg::SampleW-1:0]    span_samples_o,
  output logic [i2cdec_pkg::CntW-1:0]       bits_in_byte_o,
  output logic [i2cdec_pkg::SampleW-1:0]    start_sample_o,
  output logic                              last_result_o
);
  import i2cdec_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // configuration
  logic [LineW-1:0] clock_line_q, data_line_q;
  logic             invert_q, addr_shift_q;

  // input register
  logic                in_valid_q;
  logic [RunW-1:0]     run_q;
  logic [PinsW-1:0]    pins_q;
  logic                first_q, last_q;

  // decoder state
  phase_e             phase_q, phase_d;
  logic               prev_clk_q, prev_clk_d, prev_dat_q, prev_dat_d;
  logic               pend_q, pend_d, is_read_q, is_read_d, seen_q, seen_d;
  logic [SampleW-1:0] ev_start_q, ev_start_d, ev_end_q, ev_end_d;
  logic [SampleW-1:0] byte_start_q, byte_start_d, sidx_q, sidx_d;
  logic [7:0]         shift_q, shift_d;
  logic [2:0]         bit_idx_q, bit_idx_d;
  logic [CntW-1:0]    bbr_q, bbr_d;
  logic [CodeW-1:0]   pcode_q, pcode_d;

  // result queue
  result_t          queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  result_t     res0, res1;
  logic [1:0]  n_res;
  logic        room, advance, pop, in_accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_line_q <= ClockLineRst;
      data_line_q  <= DataLineRst;
      invert_q     <= 1'b0;
      addr_shift_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegClockLine: clock_line_q <= cfg_data_i;
        RegDataLine:  data_line_q  <= cfg_data_i;
        RegInvert:    invert_q     <= cfg_data_i[0];
        RegAddrShift: addr_shift_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pop        = out_valid_o && !out_stall_i;
  // leave space for two events after this cycle's pop
  assign room       = ({1'b0, count_q} - {{QCntW{1'b0}}, pop}) <= (QCntW+1)'(QDepth - 2);
  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      run_q   <= run_minus_one_i;
      pins_q  <= pins_i;
      first_q <= first_of_capture_i;
      last_q  <= last_of_capture_i;
    end
  end

  // one run of the decoder
  always_comb begin
    logic       lines_ok, scl, sda, rise, fall_sda, rise_sda;
    logic [2:0] clk_sel, dat_sel;
    logic [SampleW-1:0] s;
    result_t    r;

    phase_d      = phase_q;
    prev_clk_d   = prev_clk_q;
    prev_dat_d   = prev_dat_q;
    pend_d       = pend_q;
    is_read_d    = is_read_q;
    seen_d       = seen_q;
    ev_start_d   = ev_start_q;
    ev_end_d     = ev_end_q;
    byte_start_d = byte_start_q;
    sidx_d       = sidx_q;
    shift_d      = shift_q;
    bit_idx_d    = bit_idx_q;
    bbr_d        = bbr_q;
    pcode_d      = pcode_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;
    r            = '0;
    s            = sidx_q;
    rise         = 1'b0;
    fall_sda     = 1'b0;
    rise_sda     = 1'b0;

    lines_ok = (clock_line_q >= 4'd1) && (clock_line_q <= 4'd8) &&
               (data_line_q >= 4'd1) && (data_line_q <= 4'd8);
    clk_sel  = clock_line_q[2:0] - 3'd1;
    dat_sel  = data_line_q[2:0] - 3'd1;
    scl      = pins_q[clk_sel] ^ invert_q;
    sda      = pins_q[dat_sel] ^ invert_q;

    if (lines_ok) begin
      if (first_q) begin
        phase_d      = PhStart;
        pend_d       = 1'b0;
        ev_start_d   = '1;
        ev_end_d     = '1;
        byte_start_d = '1;
        shift_d      = '0;
        bit_idx_d    = '0;
        bbr_d        = '0;
        is_read_d    = 1'b0;
        seen_d       = 1'b0;
        pcode_d      = EvStart;
        sidx_d       = '0;
        prev_clk_d   = scl;
        prev_dat_d   = sda;
      end

      s        = sidx_d;
      rise     = !prev_clk_d && scl;
      fall_sda = prev_dat_d && !sda && scl;
      rise_sda = !prev_dat_d && sda && scl;

      // flush the pending event ahead of whatever this edge starts
      if (pend_d && ((phase_d != PhStart && rise) ||
                     (phase_d == PhData && (fall_sda || rise_sda)))) begin
        res0   = '{code: pcode_d, byte_val: shift_d, span: ev_end_d - ev_start_d,
                   bits: bbr_d, start: ev_start_d, last: 1'b0};
        n_res  = 2'd1;
        bbr_d  = '0;
        shift_d = '0;
        pend_d = 1'b0;
      end

      if ((phase_d == PhAddr || phase_d == PhData) && rise) begin
        shift_d = {shift_d[6:0], sda};
        if (bit_idx_d == 3'd0) byte_start_d = s;
        if (bit_idx_d != 3'(LastBit)) begin
          bit_idx_d = bit_idx_d + 3'd1;
        end else begin
          if (phase_d == PhAddr) begin
            is_read_d = shift_d[0];
            if (addr_shift_q) shift_d = {1'b0, shift_d[7:1]};
            pcode_d = is_read_d ? EvReadAddr : EvWriteAddr;
          end else begin
            pcode_d = is_read_d ? EvDataRead : EvDataWrite;
          end
          bbr_d      = 4'd8;
          ev_start_d = byte_start_d;
          ev_end_d   = s;
          bit_idx_d  = '0;
          phase_d    = PhAck;
          pend_d     = 1'b1;
        end
      end else if ((phase_d == PhStart || phase_d == PhData) && fall_sda) begin
        ev_start_d = s;
        ev_end_d   = s;
        pcode_d    = seen_d ? EvRepStart : EvStart;
        phase_d    = PhAddr;
        bit_idx_d  = '0;
        shift_d    = '0;
        seen_d     = 1'b1;
        pend_d     = 1'b1;
      end else if (phase_d == PhData && rise_sda) begin
        ev_start_d = s;
        ev_end_d   = s;
        phase_d    = PhStart;
        seen_d     = 1'b0;
        r = '{code: EvStop, byte_val: 8'd0, span: '0, bits: bbr_d, start: s, last: 1'b0};
        if (n_res == 2'd0) res0 = r;
        else               res1 = r;
        n_res   = n_res + 2'd1;
        bbr_d   = '0;
        shift_d = '0;
        pend_d  = 1'b0;
        pcode_d = EvStop;
      end else if (phase_d == PhAck && rise) begin
        ev_start_d = s;
        ev_end_d   = s;
        pcode_d    = sda ? EvNack : EvAck;
        phase_d    = PhData;
        pend_d     = 1'b1;
      end else if (phase_d != PhStart) begin
        ev_end_d = ev_end_d + 32'd1;
      end

      prev_clk_d = scl;
      prev_dat_d = sda;
      if (phase_d != PhStart) ev_end_d = ev_end_d + SampleW'(run_q);
      sidx_d = s + SampleW'(run_q) + 32'd1;

      if (last_q && pend_d) begin
        r = '{code: pcode_d, byte_val: shift_d, span: ev_end_d - ev_start_d,
              bits: bbr_d, start: ev_start_d, last: 1'b0};
        if (n_res == 2'd0) res0 = r;
        else               res1 = r;
        n_res   = n_res + 2'd1;
        bbr_d   = '0;
        shift_d = '0;
        pend_d  = 1'b0;
      end

      if (n_res == 2'd2) res1.last = 1'b1;
      else               res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      prev_clk_q   <= 1'b1;
      prev_dat_q   <= 1'b1;
      pend_q       <= 1'b0;
      is_read_q    <= 1'b0;
      seen_q       <= 1'b0;
      ev_start_q   <= '1;
      ev_end_q     <= '1;
      byte_start_q <= '1;
      sidx_q       <= '0;
      shift_q      <= '0;
      bit_idx_q    <= '0;
      bbr_q        <= '0;
      pcode_q      <= EvStart;
    end else if (advance) begin
      phase_q      <= phase_d;
      prev_clk_q   <= prev_clk_d;
      prev_dat_q   <= prev_dat_d;
      pend_q       <= pend_d;
      is_read_q    <= is_read_d;
      seen_q       <= seen_d;
      ev_start_q   <= ev_start_d;
      ev_end_q     <= ev_end_d;
      byte_start_q <= byte_start_d;
      sidx_q       <= sidx_d;
      shift_q      <= shift_d;
      bit_idx_q    <= bit_idx_d;
      bbr_q        <= bbr_d;
      pcode_q      <= pcode_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (advance) wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_q + (advance ? QCntW'(n_res) : '0) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && n_res != 2'd0) queue_q[wr_ptr_q] <= res0;
    if (advance && n_res == 2'd2) queue_q[wr_ptr_q + QPtrW'(1)] <= res1;
  end

  assign out_valid_o    = count_q != '0;
  assign event_code_o   = queue_q[rd_ptr_q].code;
  assign byte_value_o   = queue_q[rd_ptr_q].byte_val;
  assign span_samples_o = queue_q[rd_ptr_q].span;
  assign bits_in_byte_o = queue_q[rd_ptr_q].bits;
  assign start_sample_o = queue_q[rd_ptr_q].start;
  assign last_result_o  = queue_q[rd_ptr_q].last;

endmodule
